// File: design/bba_pkg.sv
// Shared types, constants and helpers for the bitmap block allocator.
// Used by bba_ctrl and bitmap_block_allocator_core; depends on nothing.
`default_nettype none

package bba_pkg;

	localparam int MAX_BLOCKS = 4096;
	localparam int BLK_W      = 12;
	localparam int CNT_W      = 13;
	localparam int WORD_W     = 32;
	localparam int WORDS      = MAX_BLOCKS / WORD_W;
	localparam int WADDR_W    = $clog2(WORDS);
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int DATA_W     = 16;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_BLOCKS   = 2'd1,
		ST_DOUBLE_FREE = 2'd2,
		ST_RANGE       = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FREE_CHK,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic                re;
		logic [WADDR_W-1:0]  raddr;
		logic                we;
		logic [WADDR_W-1:0]  waddr;
		logic [WORD_W-1:0]   wdata;
	} mem_req_t;

	// Single set bit at the given position of a bitmap word.
	function automatic logic [WORD_W-1:0] bit_mask(input logic [BIT_W-1:0] pos);
		logic [WORD_W-1:0] m;
		m = '0;
		m[pos] = 1'b1;
		return m;
	endfunction

	// Position of the lowest set bit; zero when the word is empty.
	function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// File: design/bba_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read port; no package dependencies.
`default_nettype none

module bba_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/bba_ctrl.sv
// Request sequencer for the allocator: bitmap scan, free check, word write-back
// and the output register. Uses bba_pkg; drives the bitmap RAM through mem_req_t.
`default_nettype none

module bba_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [bba_pkg::CNT_W-1:0]     cfg_wr_data,
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	input  wire logic [bba_pkg::DATA_W-1:0]    s_tdata,
	input  wire logic                          s_tuser,
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	output      logic [bba_pkg::DATA_W-1:0]    m_tdata,
	output      logic [1:0]                    m_tuser,
	output      bba_pkg::mem_req_t             mem_req,
	input  wire logic [bba_pkg::WORD_W-1:0]    mem_rdata
);

	import bba_pkg::*;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     total_q;
	logic [CNT_W-1:0]     cnt;
	logic [CNT_W-1:0]     cnt_m1;
	logic [WADDR_W-1:0]   last_word;
	logic [WORD_W-1:0]    tail_mask;
	logic [WORD_W-1:0]    limit_mask;
	logic [WORDS-1:0]     valid_q;
	logic                 vld_s1;
	logic [WADDR_W-1:0]   addr_s1;
	logic [BLK_W-1:0]     blk_q;
	logic [WORD_W-1:0]    word_s1;
	logic [WORD_W-1:0]    free_bits;
	logic [BIT_W-1:0]     free_idx;
	logic                 found;
	logic [BLK_W-1:0]     in_blk;
	logic                 set_res;
	status_t              res_status_d, res_status_q;
	logic [BLK_W-1:0]     res_grant_d, res_grant_q;
	logic                 out_load;
	logic                 m_valid_q;
	status_t              m_status_q;
	logic [BLK_W-1:0]     m_grant_q;

	assign in_blk = s_tdata[BLK_W-1:0];

	// Managed count, clamped to the map capacity.
	assign cnt    = (total_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_q;
	assign cnt_m1 = cnt - CNT_W'(1);
	assign last_word = cnt_m1[BLK_W-1:BIT_W];
	assign tail_mask = (cnt[BIT_W-1:0] == '0) ? '1
		: ((WORD_W'(1) << cnt[BIT_W-1:0]) - WORD_W'(1));
	assign limit_mask = (addr_s1 == last_word) ? tail_mask : '1;

	// A word never written since reset reads as all free.
	assign word_s1   = vld_s1 ? mem_rdata : '0;
	assign free_bits = ~word_s1 & limit_mask;
	assign found     = (free_bits != '0);
	assign free_idx  = lowest_set(free_bits);

	always_comb begin
		s_tready     = 1'b0;
		mem_req      = '0;
		set_res      = 1'b0;
		res_status_d = ST_OK;
		res_grant_d  = '0;
		out_load     = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == MODE_ALLOC) begin
						if (cnt == '0) begin
							set_res      = 1'b1;
							res_status_d = ST_NO_BLOCKS;
						end else begin
							mem_req.re    = 1'b1;
							mem_req.raddr = '0;
						end
					end else begin
						if ({1'b0, in_blk} >= cnt) begin
							set_res      = 1'b1;
							res_status_d = ST_RANGE;
						end else begin
							mem_req.re    = 1'b1;
							mem_req.raddr = in_blk[BLK_W-1:BIT_W];
						end
					end
				end
			end
			S_SCAN: begin
				if (found) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = addr_s1;
					mem_req.wdata = word_s1 | bit_mask(free_idx);
					set_res       = 1'b1;
					res_status_d  = ST_OK;
					res_grant_d   = {addr_s1, free_idx};
				end else if (addr_s1 == last_word) begin
					set_res      = 1'b1;
					res_status_d = ST_NO_BLOCKS;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = addr_s1 + WADDR_W'(1);
				end
			end
			S_FREE_CHK: begin
				set_res = 1'b1;
				if (word_s1[blk_q[BIT_W-1:0]]) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = blk_q[BLK_W-1:BIT_W];
					mem_req.wdata = word_s1 & ~bit_mask(blk_q[BIT_W-1:0]);
					res_status_d  = ST_OK;
				end else begin
					res_status_d = ST_DOUBLE_FREE;
				end
			end
			S_RESULT: begin
				out_load = !m_valid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (set_res) begin
						state_d = S_RESULT;
					end else if (s_tuser == MODE_ALLOC) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_FREE_CHK;
					end
				end
			end
			S_SCAN: begin
				if (set_res) begin
					state_d = S_RESULT;
				end
			end
			S_FREE_CHK: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			total_q   <= CNT_W'(MAX_BLOCKS);
			valid_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				total_q <= cfg_wr_data;
			end
			if (mem_req.we) begin
				valid_q[mem_req.waddr] <= 1'b1;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_req.re) begin
			addr_s1 <= mem_req.raddr;
			vld_s1  <= valid_q[mem_req.raddr];
		end
		if (s_tvalid && s_tready) begin
			blk_q <= in_blk;
		end
		if (set_res) begin
			res_status_q <= res_status_d;
			res_grant_q  <= res_grant_d;
		end
		if (out_load) begin
			m_status_q <= res_status_q;
			m_grant_q  <= res_grant_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {{(DATA_W - BLK_W){1'b0}}, m_grant_q};

`ifndef SYNTH
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_req.we)
		else $error("bitmap written while idle");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |=> !mem_req.we)
		else $error("bitmap written twice for one request");
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_grant_q == '0))
		else $error("nonzero grant on a failed request");
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_OK) |-> ({1'b0, m_grant_q} < cnt))
		else $error("grant at or above the managed count");
`endif

endmodule

`default_nettype wire

// File: design/bitmap_block_allocator_core.sv
// Top level of the bitmap first-fit block allocator.
// Uses bba_pkg, bba_ctrl (sequencer) and bba_ram (bitmap store, 128 x 32 bits).
//
//   Channel   Signals                                   Carries
//   s_*       s_tvalid s_tready s_tdata s_tuser          request: block_number, mode
//   m_*       m_tvalid m_tready m_tdata m_tuser          result: granted_block, status
//   cfg_*     cfg_wr_en cfg_wr_data                      total_blocks register
//
// A free request passes through the free-check and result states to the output
// register; an out-of-range free or an allocate with a zero count goes straight
// to the result state. An allocate reads one 32-bit bitmap word per cycle from
// the RAM read port until a word with a free block or the last word is reached.
// Reset needs no clearing pass: a valid flop per word marks it as written.
// A new request is accepted while the previous result waits in the output
// register; the sequencer holds in its result state if that register is full.
`default_nettype none

module bitmap_block_allocator_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [bba_pkg::CNT_W-1:0]     cfg_wr_data,
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	input  wire logic [bba_pkg::DATA_W-1:0]    s_tdata,  // [11:0] block_number, rest zero
	input  wire logic                          s_tuser,  // [0] mode
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	output      logic [bba_pkg::DATA_W-1:0]    m_tdata,  // [11:0] granted_block, rest zero
	output      logic [1:0]                    m_tuser   // [1:0] status
);

	import bba_pkg::*;

	mem_req_t            mem_req;
	logic [WORD_W-1:0]   mem_rdata;

	bba_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata)
	);

	bba_ram #(
		.DEPTH (WORDS),
		.WIDTH (WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire
